// ----- rtl/core/obct_pkg.sv -----
package obct_pkg;

    localparam int NUM_CORNERS  = 4;
    localparam int NUM_AXES     = 4;
    // corners of both prisms side by side: reference first, then the item
    localparam int NUM_PTS      = 2 * NUM_CORNERS;
    // coordinate fields carried in s_tdata: 8 corner values, floor, ceiling
    localparam int NUM_FIELDS   = 10;
    // lane pipeline: products, dot sums, min/max, interval compare
    localparam int LANE_STAGES  = 4;
    // reference coordinates must hold +/-256 whatever the coordinate width
    localparam int MIN_REF_BITS = 10;
    localparam int OUT_DATA_W   = 8;

    // square with corners at +/-1.0 in Q8.8 and a one-unit tall extent
    localparam int REF_CORNER_X [NUM_CORNERS] = '{-256, -256, 256, 256};
    localparam int REF_CORNER_Z [NUM_CORNERS] = '{-256, 256, 256, -256};
    localparam int REF_FLOOR    = 0;
    localparam int REF_CEILING  = 256;

    localparam logic MODE_STORE = 1'b0;
    localparam logic MODE_TEST  = 1'b1;

    typedef struct packed {
        logic                valid;
        logic                height;
        logic [NUM_AXES-1:0] overlap;
    } merge_in_t;

    typedef struct packed {
        logic height;
        logic plane;
        logic hit;
    } result_t;

endpackage

// ----- rtl/core/obct_lane.sv -----
module obct_lane
    import obct_pkg::*;
#(
    parameter int CW = 16
) (
    input  logic                aclk,
    input  logic                adv,
    input  logic signed [CW-1:0] cx [NUM_PTS],
    input  logic signed [CW-1:0] cz [NUM_PTS],
    input  logic signed [CW:0]   ax,
    input  logic signed [CW:0]   az,
    output logic                overlap
);

    localparam int PW = 2 * CW + 1;
    localparam int DW = PW + 1;

    logic signed [PW-1:0] prod_x_reg [NUM_PTS];
    logic signed [PW-1:0] prod_z_reg [NUM_PTS];
    logic signed [DW-1:0] dot_reg [NUM_PTS];
    logic signed [DW-1:0] mn1_reg, mx1_reg, mn2_reg, mx2_reg;
    logic signed [DW-1:0] mn1_next, mx1_next, mn2_next, mx2_next;
    logic signed [DW-1:0] lo_a, lo_b, hi_a, hi_b, lo_c, lo_d, hi_c, hi_d;
    logic                 overlap_reg, overlap_next;

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int j = 0; j < NUM_PTS; j++) begin
                prod_x_reg[j] <= PW'(cx[j]) * PW'(ax);
                prod_z_reg[j] <= PW'(cz[j]) * PW'(az);
                dot_reg[j]    <= DW'(prod_x_reg[j]) + DW'(prod_z_reg[j]);
            end
            mn1_reg     <= mn1_next;
            mx1_reg     <= mx1_next;
            mn2_reg     <= mn2_next;
            mx2_reg     <= mx2_next;
            overlap_reg <= overlap_next;
        end
    end

    // two-level min/max trees, reference corners and item corners
    always_comb begin
        lo_a = (dot_reg[1] < dot_reg[0]) ? dot_reg[1] : dot_reg[0];
        hi_a = (dot_reg[1] > dot_reg[0]) ? dot_reg[1] : dot_reg[0];
        lo_b = (dot_reg[3] < dot_reg[2]) ? dot_reg[3] : dot_reg[2];
        hi_b = (dot_reg[3] > dot_reg[2]) ? dot_reg[3] : dot_reg[2];
        lo_c = (dot_reg[5] < dot_reg[4]) ? dot_reg[5] : dot_reg[4];
        hi_c = (dot_reg[5] > dot_reg[4]) ? dot_reg[5] : dot_reg[4];
        lo_d = (dot_reg[7] < dot_reg[6]) ? dot_reg[7] : dot_reg[6];
        hi_d = (dot_reg[7] > dot_reg[6]) ? dot_reg[7] : dot_reg[6];
        mn1_next = (lo_b < lo_a) ? lo_b : lo_a;
        mx1_next = (hi_b > hi_a) ? hi_b : hi_a;
        mn2_next = (lo_d < lo_c) ? lo_d : lo_c;
        mx2_next = (hi_d > hi_c) ? hi_d : hi_c;
    end

    // the interval starting lower must reach the other's start
    always_comb begin
        if (mn2_reg < mn1_reg) begin
            overlap_next = (mx2_reg >= mn1_reg);
        end else begin
            overlap_next = (mx1_reg >= mn2_reg);
        end
    end

    assign overlap = overlap_reg;

endmodule

// ----- rtl/core/obct_merge.sv -----
module obct_merge
    import obct_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  merge_in_t             lane_in,
    output logic                  adv,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata
);

    logic    out_valid_reg;
    result_t res_reg, res_next;

    assign adv = !out_valid_reg || m_tready;

    always_comb begin
        res_next.plane  = &lane_in.overlap;
        res_next.height = lane_in.height;
        res_next.hit    = res_next.plane & lane_in.height;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= lane_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'(res_reg);

endmodule

// ----- rtl/core/oriented_box_collision_test_top.sv -----
// Channel  | Dir | Signals                    | Content
// ---------+-----+----------------------------+----------------------------------------
// s_       | in  | s_tvalid/tready/tdata/tuser| prism corners, floor, ceiling; tuser=mode
// m_       | out | m_tvalid/tready/tdata      | hit, plane_overlap, height_overlap
//
// One item per cycle while the output is not stalled. A test transfer gives its result through
// capture (loaded on the accepting edge) and axis stages, four stages in each of the four axis lanes
// (one bank of 16 multipliers per lane), then the result register. Store transfers update
// the reference at once and give no result. Reset clears the reference to a square with
// corners at +/-1.0, floor 0, ceiling 1.0. When the result register is full and m_tready is low,
// the whole pipeline holds and s_tready drops.
module oriented_box_collision_test_top
    import obct_pkg::*;
#(
    parameter  int COORD_BITS = 16,
    localparam int S_DATA_W   = ((NUM_FIELDS * COORD_BITS + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // c0_x, c0_z, c1_x, c1_z, c2_x, c2_z, c3_x, c3_z, floor_y, ceiling_y
    input  logic [S_DATA_W-1:0]   s_tdata,
    // mode
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // hit, plane_overlap, height_overlap, zero fill
    output logic [OUT_DATA_W-1:0] m_tdata
);

    localparam int W  = COORD_BITS;
    localparam int RW = (COORD_BITS < MIN_REF_BITS) ? MIN_REF_BITS : COORD_BITS;

    logic adv, accept;

    logic signed [W-1:0]  in_x [NUM_CORNERS];
    logic signed [W-1:0]  in_z [NUM_CORNERS];
    logic signed [W-1:0]  in_fl, in_ce;

    logic signed [RW-1:0] ref_x_reg [NUM_CORNERS];
    logic signed [RW-1:0] ref_z_reg [NUM_CORNERS];
    logic signed [RW-1:0] ref_fl_reg, ref_ce_reg;

    logic                 v1_reg;
    logic signed [RW-1:0] st1_x_reg [NUM_PTS];
    logic signed [RW-1:0] st1_z_reg [NUM_PTS];
    logic signed [RW-1:0] st1_rfl_reg, st1_rce_reg, st1_fl_reg, st1_ce_reg;

    logic                 v2_reg;
    logic                 h2_reg, h2_next;
    logic signed [RW-1:0] st2_x_reg [NUM_PTS];
    logic signed [RW-1:0] st2_z_reg [NUM_PTS];
    logic signed [RW:0]   ax_reg [NUM_AXES];
    logic signed [RW:0]   az_reg [NUM_AXES];

    logic [LANE_STAGES-1:0] v_dly_reg;
    logic [LANE_STAGES-1:0] h_dly_reg;
    logic [NUM_AXES-1:0]    lane_ov;
    merge_in_t              merge_in;

    logic                 ref_lower;
    logic signed [RW-1:0] t1, b2, t2;

    assign s_tready = adv;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        for (int i = 0; i < NUM_CORNERS; i++) begin
            in_x[i] = s_tdata[(2 * i) * W +: W];
            in_z[i] = s_tdata[(2 * i + 1) * W +: W];
        end
        in_fl = s_tdata[(2 * NUM_CORNERS) * W +: W];
        in_ce = s_tdata[(2 * NUM_CORNERS + 1) * W +: W];
    end

    // reference prism
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CORNERS; i++) begin
                ref_x_reg[i] <= RW'(REF_CORNER_X[i]);
                ref_z_reg[i] <= RW'(REF_CORNER_Z[i]);
            end
            ref_fl_reg <= RW'(REF_FLOOR);
            ref_ce_reg <= RW'(REF_CEILING);
        end else if (accept && s_tuser == MODE_STORE) begin
            for (int i = 0; i < NUM_CORNERS; i++) begin
                ref_x_reg[i] <= RW'(in_x[i]);
                ref_z_reg[i] <= RW'(in_z[i]);
            end
            ref_fl_reg <= RW'(in_fl);
            ref_ce_reg <= RW'(in_ce);
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v_dly_reg <= '0;
        end else if (adv) begin
            v1_reg    <= accept && s_tuser == MODE_TEST;
            v2_reg    <= v1_reg;
            v_dly_reg <= {v_dly_reg[LANE_STAGES-2:0], v2_reg};
        end
    end

    // height rule: the prism with the lower floor (item on ties) is the lower one
    always_comb begin
        ref_lower = st1_rfl_reg < st1_fl_reg;
        t1        = ref_lower ? st1_rce_reg : st1_ce_reg;
        b2        = ref_lower ? st1_fl_reg  : st1_rfl_reg;
        t2        = ref_lower ? st1_ce_reg  : st1_rce_reg;
        h2_next   = (t1 >= b2 && t1 <= t2) || (t1 >= t2);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < NUM_CORNERS; i++) begin
                st1_x_reg[i]               <= ref_x_reg[i];
                st1_z_reg[i]               <= ref_z_reg[i];
                st1_x_reg[i + NUM_CORNERS] <= RW'(in_x[i]);
                st1_z_reg[i + NUM_CORNERS] <= RW'(in_z[i]);
            end
            st1_rfl_reg <= ref_fl_reg;
            st1_rce_reg <= ref_ce_reg;
            st1_fl_reg  <= RW'(in_fl);
            st1_ce_reg  <= RW'(in_ce);

            st2_x_reg <= st1_x_reg;
            st2_z_reg <= st1_z_reg;
            h2_reg    <= h2_next;
            // edges c3-c0 and c2-c3 of the reference, then of the item
            for (int p = 0; p < 2; p++) begin
                ax_reg[2 * p]     <= (RW + 1)'(st1_x_reg[4 * p + 3])
                                   - (RW + 1)'(st1_x_reg[4 * p]);
                az_reg[2 * p]     <= (RW + 1)'(st1_z_reg[4 * p + 3])
                                   - (RW + 1)'(st1_z_reg[4 * p]);
                ax_reg[2 * p + 1] <= (RW + 1)'(st1_x_reg[4 * p + 2])
                                   - (RW + 1)'(st1_x_reg[4 * p + 3]);
                az_reg[2 * p + 1] <= (RW + 1)'(st1_z_reg[4 * p + 2])
                                   - (RW + 1)'(st1_z_reg[4 * p + 3]);
            end

            h_dly_reg <= {h_dly_reg[LANE_STAGES-2:0], h2_reg};
        end
    end

    for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
        obct_lane #(
            .CW (RW)
        ) u_lane (
            .aclk    (aclk),
            .adv     (adv),
            .cx      (st2_x_reg),
            .cz      (st2_z_reg),
            .ax      (ax_reg[a]),
            .az      (az_reg[a]),
            .overlap (lane_ov[a])
        );
    end

    assign merge_in.valid   = v_dly_reg[LANE_STAGES-1];
    assign merge_in.height  = h_dly_reg[LANE_STAGES-1];
    assign merge_in.overlap = lane_ov;

    obct_merge u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .lane_in  (merge_in),
        .adv      (adv),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ----- rtl/core/obct_checker.sv -----
module obct_checker
    import obct_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_hit_rule: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[0] == (m_tdata[1] & m_tdata[2]))
        else $error("hit is not plane and height overlap");

    a_zero_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[OUT_DATA_W-1:3] == '0)
        else $error("result fill bits not zero");

    // an empty result register never blocks the input side
    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind oriented_box_collision_test_top obct_checker u_obct_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- tb/oriented_box_collision_test_top_tb.sv -----
`timescale 1ns / 100ps

module oriented_box_collision_test_top_tb;
    import obct_pkg::*;

    localparam int COORD_BITS = 16;
    localparam int S_DATA_W   = ((NUM_FIELDS * COORD_BITS + 7) / 8) * 8;
    localparam int IDLE_LIMIT = 2000;
    localparam int RAND_ITEMS = 1080;
    localparam int HOLD_LEN   = 120;
    localparam int MAX_REPORTS = 30;
    localparam int SQ = 256;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    // first member in the top bits, so c0_x lands in s_tdata[15:0]
    typedef struct packed {
        coord_t ceiling_y, floor_y, c3_z, c3_x, c2_z, c2_x, c1_z, c1_x, c0_z, c0_x;
    } prism_t;

    typedef struct {
        logic     mode;
        prism_t   p;
        bit       fixed;
        logic [2:0] res;    // {height, plane, hit}
    } dir_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;

    // reference prism as the block should hold it, and the item under test
    longint ref_x [NUM_CORNERS];
    longint ref_z [NUM_CORNERS];
    longint ref_fl, ref_ce;
    longint itm_x [NUM_CORNERS];
    longint itm_z [NUM_CORNERS];

    result_t  outcome_q [$];
    dir_row_t dir_rows [$];

    int  err_cnt = 0;
    int  n_loads = 0;
    int  n_queries = 0;
    int  n_results = 0;
    int  n_hits = 0;
    int  n_plane = 0;
    int  idle_cycles = 0;
    int  gap_burst = 0;
    bit  hold_req = 0;

    oriented_box_collision_test_top #(.COORD_BITS(COORD_BITS)) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    function automatic prism_t prism(int x0, int z0, int x1, int z1, int x2, int z2,
                                     int x3, int z3, int fl, int ce);
        prism_t p;
        p.c0_x = coord_t'(x0); p.c0_z = coord_t'(z0);
        p.c1_x = coord_t'(x1); p.c1_z = coord_t'(z1);
        p.c2_x = coord_t'(x2); p.c2_z = coord_t'(z2);
        p.c3_x = coord_t'(x3); p.c3_z = coord_t'(z3);
        p.floor_y = coord_t'(fl); p.ceiling_y = coord_t'(ce);
        return p;
    endfunction

    // axis-aligned square, corners in the same winding as the reset reference
    function automatic prism_t square(int cx, int cz, int h, int fl, int ce);
        return prism(cx - h, cz - h, cx - h, cz + h, cx + h, cz + h, cx + h, cz - h, fl, ce);
    endfunction

    function automatic bit axis_overlaps(longint ax, longint az);
        longint d, lo_r, hi_r, lo_i, hi_i, t;
        lo_r = ref_x[0] * ax + ref_z[0] * az;
        hi_r = lo_r;
        lo_i = itm_x[0] * ax + itm_z[0] * az;
        hi_i = lo_i;
        for (int j = 1; j < NUM_CORNERS; j++) begin
            d = ref_x[j] * ax + ref_z[j] * az;
            if (d < lo_r) lo_r = d;
            if (d > hi_r) hi_r = d;
            d = itm_x[j] * ax + itm_z[j] * az;
            if (d < lo_i) lo_i = d;
            if (d > hi_i) hi_i = d;
        end
        // the interval with the smaller minimum goes on the left
        if (lo_i < lo_r) begin
            t = lo_r; lo_r = lo_i; lo_i = t;
            t = hi_r; hi_r = hi_i; hi_i = t;
        end
        return !(hi_r < lo_i);
    endfunction

    function automatic result_t collide(prism_t p);
        longint ax [NUM_AXES];
        longint az [NUM_AXES];
        longint fl, ce, t1, b2, t2;
        result_t r;
        itm_x[0] = p.c0_x; itm_z[0] = p.c0_z;
        itm_x[1] = p.c1_x; itm_z[1] = p.c1_z;
        itm_x[2] = p.c2_x; itm_z[2] = p.c2_z;
        itm_x[3] = p.c3_x; itm_z[3] = p.c3_z;
        ax[0] = ref_x[3] - ref_x[0]; az[0] = ref_z[3] - ref_z[0];
        ax[1] = ref_x[2] - ref_x[3]; az[1] = ref_z[2] - ref_z[3];
        ax[2] = itm_x[3] - itm_x[0]; az[2] = itm_z[3] - itm_z[0];
        ax[3] = itm_x[2] - itm_x[3]; az[3] = itm_z[2] - itm_z[3];
        r.plane = 1'b1;
        for (int i = 0; i < NUM_AXES; i++)
            if (!axis_overlaps(ax[i], az[i])) r.plane = 1'b0;
        fl = p.floor_y;
        ce = p.ceiling_y;
        // lower prism by floor; a tie makes the item the lower one
        if (ref_fl < fl) begin
            t1 = ref_ce; b2 = fl; t2 = ce;
        end else begin
            t1 = ce; b2 = ref_fl; t2 = ref_ce;
        end
        r.height = (t1 >= b2 && t1 <= t2) || (t1 >= t2);
        r.hit    = r.plane & r.height;
        return r;
    endfunction

    task automatic load_reference(prism_t p);
        ref_x[0] = p.c0_x; ref_z[0] = p.c0_z;
        ref_x[1] = p.c1_x; ref_z[1] = p.c1_z;
        ref_x[2] = p.c2_x; ref_z[2] = p.c2_z;
        ref_x[3] = p.c3_x; ref_z[3] = p.c3_z;
        ref_fl = p.floor_y;
        ref_ce = p.ceiling_y;
    endtask

    task automatic sender_gap();
        int g;
        if (gap_burst > 0) begin
            gap_burst--;
            return;
        end
        g = $urandom_range(0, 99);
        if (g < 50)      g = 0;
        else if (g < 92) g = $urandom_range(1, 3);
        else             g = $urandom_range(10, 40);
        if (g > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (g - 1) @(negedge aclk);
        end
    endtask

    task automatic send_item(logic mode, prism_t p, bit fixed, logic [2:0] res);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= p;
        do @(posedge aclk); while (!s_tready);
        if (mode == MODE_STORE) begin
            load_reference(p);
            n_loads++;
        end else begin
            outcome_q.push_back(fixed ? result_t'(res) : collide(p));
            n_queries++;
        end
        sender_gap();
    endtask

    // random oriented box near the origin, edges along (dx,dz) and its normal
    function automatic prism_t rand_box();
        int cx, cz, dx, dz, ka, kb, fl;
        int ax, az, bx, bz;
        cx = int'($urandom_range(0, 1600)) - 800;
        cz = int'($urandom_range(0, 1600)) - 800;
        dx = int'($urandom_range(0, 128)) - 64;
        dz = int'($urandom_range(0, 128)) - 64;
        ka = int'($urandom_range(0, 12));
        kb = int'($urandom_range(0, 12));
        ax = dx * ka; az = dz * ka;
        bx = -dz * kb; bz = dx * kb;
        fl = int'($urandom_range(0, 1200)) - 600;
        return prism(cx - ax - bx, cz - az - bz, cx - ax + bx, cz - az + bz,
                     cx + ax + bx, cz + az + bz, cx + ax - bx, cz + az - bz,
                     fl, fl + int'($urandom_range(0, 900)) - 100);
    endfunction

    function automatic prism_t rand_extremes();
        logic [S_DATA_W-1:0] v;
        v = '0;
        for (int f = 0; f < NUM_FIELDS; f++) begin
            case ($urandom_range(0, 4))
                0: v[f*COORD_BITS +: COORD_BITS] = 16'h8000;
                1: v[f*COORD_BITS +: COORD_BITS] = 16'h7fff;
                2: v[f*COORD_BITS +: COORD_BITS] = 16'h0000;
                3: v[f*COORD_BITS +: COORD_BITS] = 16'hffff;
                default: v[f*COORD_BITS +: COORD_BITS] = COORD_BITS'($urandom);
            endcase
        end
        return prism_t'(v);
    endfunction

    task automatic report(string what, bit want, bit got);
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0b, actual %0b", $time, what, want, got);
    endtask

    // result checker
    always @(posedge aclk) begin : chk_result
        result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = result_t'(m_tdata[2:0]);
            n_results++;
            if (got.hit) n_hits++;
            if (got.plane) n_plane++;
            if (outcome_q.size() == 0) begin
                err_cnt++;
                if (err_cnt <= MAX_REPORTS)
                    $display("%0t: unexpected result, expected none, actual %b",
                             $time, m_tdata[2:0]);
            end else begin
                want = outcome_q.pop_front();
                if (got.hit !== want.hit)       report("hit", want.hit, got.hit);
                if (got.plane !== want.plane)   report("plane_overlap", want.plane, got.plane);
                if (got.height !== want.height) report("height_overlap", want.height, got.height);
            end
        end
    end

    // watchdog on transfers in either direction
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                     $time, IDLE_LIMIT, outcome_q.size());
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // receiver: random ready/stall runs, plus one long hold-off on request
    initial begin
        int hold_left, run_left, stall_left, k;
        hold_left = 0;
        run_left = 0;
        stall_left = 0;
        m_tready = 1'b0;
        forever @(negedge aclk) begin
            if (hold_req) begin
                hold_req = 0;
                hold_left = HOLD_LEN;
            end
            if (!aresetn) begin
                m_tready <= 1'b0;
            end else if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (run_left > 0) begin
                m_tready <= 1'b1;
                run_left--;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                run_left = $urandom_range(0, 40);
                k = $urandom_range(0, 99);
                if (k < 30)      stall_left = 0;
                else if (k < 94) stall_left = $urandom_range(1, 3);
                else             stall_left = $urandom_range(10, 40);
            end
        end
    end

    initial begin
        prism_t p;
        logic   mode;
        int     k;

        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tuser  = MODE_STORE;
        s_tdata  = '0;
        for (int j = 0; j < NUM_CORNERS; j++) begin
            ref_x[j] = REF_CORNER_X[j];
            ref_z[j] = REF_CORNER_Z[j];
        end
        ref_fl = REF_FLOOR;
        ref_ce = REF_CEILING;

        // against the reset reference
        dir_rows.push_back(dir_row_t'{MODE_TEST, square(0, 0, SQ, 0, SQ), 1'b1, 3'b111});
        dir_rows.push_back(dir_row_t'{MODE_TEST, square(768, 0, SQ, 0, SQ), 1'b1, 3'b100});
        dir_rows.push_back(dir_row_t'{MODE_TEST, square(0, 0, SQ, 512, 768), 1'b1, 3'b010});
        // every corner at one point: zero-length axes overlap
        dir_rows.push_back(dir_row_t'{MODE_TEST, prism(0, 0, 0, 0, 0, 0, 0, 0, 0, SQ),
                                      1'b1, 3'b111});
        // edges and heights just touching, equal floors, ceiling below floor
        dir_rows.push_back(dir_row_t'{MODE_TEST, square(512, 0, SQ, 0, SQ), 1'b0, 3'b000});
        dir_rows.push_back(dir_row_t'{MODE_TEST, square(0, 0, SQ, 0, 100), 1'b0, 3'b000});
        dir_rows.push_back(dir_row_t'{MODE_TEST, square(0, 0, SQ, SQ, 512), 1'b0, 3'b000});
        dir_rows.push_back(dir_row_t'{MODE_TEST, square(0, 0, SQ, 100, -100), 1'b0, 3'b000});
        // field extremes
        dir_rows.push_back(dir_row_t'{MODE_TEST, prism_t'({NUM_FIELDS{16'h7fff}}),
                                      1'b0, 3'b000});
        dir_rows.push_back(dir_row_t'{MODE_TEST, prism_t'({NUM_FIELDS{16'h8000}}),
                                      1'b0, 3'b000});
        dir_rows.push_back(dir_row_t'{MODE_TEST,
            prism(32767, -32768, -32768, 32767, 32767, 32767, -32768, -32768, -32768, 32767),
            1'b0, 3'b000});
        // rotated reference
        dir_rows.push_back(dir_row_t'{MODE_STORE,
            prism(0, -512, -512, 0, 0, 512, 512, 0, -SQ, SQ), 1'b0, 3'b000});
        dir_rows.push_back(dir_row_t'{MODE_TEST, square(0, 0, SQ, 0, SQ), 1'b0, 3'b000});
        dir_rows.push_back(dir_row_t'{MODE_TEST, square(600, 600, SQ, 0, SQ), 1'b0, 3'b000});
        // reference spanning the whole coordinate range
        dir_rows.push_back(dir_row_t'{MODE_STORE,
            prism(-32768, -32768, -32768, 32767, 32767, 32767, 32767, -32768, -32768, 32767),
            1'b0, 3'b000});
        dir_rows.push_back(dir_row_t'{MODE_TEST, square(0, 0, SQ, 0, SQ), 1'b0, 3'b000});
        dir_rows.push_back(dir_row_t'{MODE_TEST, prism_t'({NUM_FIELDS{16'h7fff}}),
                                      1'b0, 3'b000});
        dir_rows.push_back(dir_row_t'{MODE_TEST,
            prism(32767, -32768, -32768, 32767, 32767, 32767, -32768, -32768, 32767, -32768),
            1'b0, 3'b000});
        // reference with ceiling below floor
        dir_rows.push_back(dir_row_t'{MODE_STORE, square(0, 0, SQ, SQ, -SQ), 1'b0, 3'b000});
        dir_rows.push_back(dir_row_t'{MODE_TEST, square(0, 0, SQ, 0, SQ), 1'b0, 3'b000});
        // collapsed reference
        dir_rows.push_back(dir_row_t'{MODE_STORE, prism_t'('0), 1'b0, 3'b000});
        dir_rows.push_back(dir_row_t'{MODE_TEST, square(SQ, 0, SQ, 0, SQ), 1'b0, 3'b000});
        dir_rows.push_back(dir_row_t'{MODE_STORE, square(0, 0, SQ, 0, SQ), 1'b0, 3'b000});

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i])
            send_item(dir_rows[i].mode, dir_rows[i].p, dir_rows[i].fixed, dir_rows[i].res);

        for (int n = 0; n < RAND_ITEMS; n++) begin
            // output held off while the input keeps streaming back to back
            if (n == 300) begin
                hold_req = 1;
                gap_burst = 60;
            end else if (n % 200 == 100) begin
                gap_burst = 50;
            end
            mode = ($urandom_range(0, 99) < 15) ? MODE_STORE : MODE_TEST;
            k = $urandom_range(0, 99);
            if (k < 75)      p = rand_box();
            else if (k < 90) p = prism_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
            else             p = rand_extremes();
            send_item(mode, p, 1'b0, 3'b000);
        end
        @(negedge aclk);
        s_tvalid <= 1'b0;

        while (outcome_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("Sent %0d reference loads and %0d collision queries, random stalls on both",
                 n_loads, n_queries);
        $display("sides and one %0d-cycle output hold; %0d results, %0d hits, %0d plane overlaps",
                 HOLD_LEN, n_results, n_hits, n_plane);
        if (err_cnt == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
